/* rtl/vec3a_pkg.sv */
// ----------------------------------------------------------------------------
// vec3a_pkg
// Shared types, constants and helpers of the Q16.16 three-component vector ALU.
// ----------------------------------------------------------------------------
package vec3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32 + FRAC_BITS;
  localparam int SQ_ST     = 32;
  localparam int NV        = 3 + SQ_ST + DW;
  localparam int QDEPTH    = 4;
  localparam int QAW       = 2;

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_DIFF   = 4'd1;
  localparam logic [3:0] OP_SCALE  = 4'd2;
  localparam logic [3:0] OP_NEG    = 4'd3;
  localparam logic [3:0] OP_SQRLEN = 4'd4;
  localparam logic [3:0] OP_LENGTH = 4'd5;
  localparam logic [3:0] OP_NORM   = 4'd6;
  localparam logic [3:0] OP_CROSS  = 4'd7;
  localparam logic [3:0] OP_DOT    = 4'd8;
  localparam logic [3:0] OP_LERP   = 4'd9;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [32:0] opnd_t;

  localparam opnd_t FX_ONE = 33'sd1 <<< FRAC_BITS;
  localparam fx_t   FX_MAX = 32'h7fffffff;
  localparam fx_t   FX_MIN = 32'h80000000;
  localparam logic signed [69:0] FX_MAX_W = 70'sd2147483647;
  localparam logic signed [69:0] FX_MIN_W = -70'sd2147483648;

  typedef struct packed {
    logic add;
    logic diff;
    logic neg;
    logic mvec;
    logic sqrlen;
    logic len;
    logic norm;
    logic dot;
  } op_t;

  typedef struct packed {
    op_t            op;
    fx_t   [2:0]    a;
    fx_t   [2:0]    b;
    opnd_t [2:0]    m0x;
    opnd_t [2:0]    m0y;
    opnd_t [2:0]    m1x;
    opnd_t [2:0]    m1y;
  } item_t;

  typedef struct packed {
    logic sat;
    fx_t  val;
  } satv_t;

  typedef struct packed {
    op_t               op;
    fx_t   [2:0]       r;
    fx_t               s;
    logic              sat;
    logic  [2:0]       neg;
    logic              zero;
    logic  [2:0][31:0] mag;
    logic  [31:0]      root;
  } pl_t;

  function automatic satv_t sat32(input logic signed [69:0] v);
    satv_t o;
    if (v > FX_MAX_W) begin
      o.sat = 1'b1;
      o.val = FX_MAX;
    end else if (v < FX_MIN_W) begin
      o.sat = 1'b1;
      o.val = FX_MIN;
    end else begin
      o.sat = 1'b0;
      o.val = v[31:0];
    end
    return o;
  endfunction

endpackage

/* rtl/vec3_fixed_point_alu_core.sv */
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu_core
// Q16.16 three-component vector ALU: add, diff, scale, neg, squared length,
// length, normalize, cross, dot and lerp, with saturation flag.
// Path: queue, operand register, product register, square root, divider, output register.
// Throughput: one request per cycle unless out_tready stalls; the whole back pipeline advances together.
// Depth is set by the 32-stage square root and the 48-stage divider.
// Reset: rst_n clears the queue and all valid bits; no configuration.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [223:0]  in_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [3:0]    in_tuser,   // func
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // r_x, r_y, r_z, scalar_out
  output logic [0:0]    out_tuser   // saturated
);

  vec3a_pkg::item_t  dec_item;
  vec3a_pkg::item_t  head;
  logic              full;
  logic              avail;
  logic              pop;
  vec3a_pkg::fx_t    rx, ry, rz, rs;
  logic              rsat;

  assign in_tready = !full;

  vec3a_front u_front (
    .func     (in_tuser),
    .vec_data (in_tdata),
    .item     (dec_item)
  );

  vec3a_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && !full),
    .push_item (dec_item),
    .full      (full),
    .pop       (pop),
    .avail     (avail),
    .head      (head)
  );

  vec3a_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .avail     (avail),
    .head      (head),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_x     (rx),
    .res_y     (ry),
    .res_z     (rz),
    .res_s     (rs),
    .res_sat   (rsat)
  );

  assign out_tdata = {rs, rz, ry, rx};
  assign out_tuser = rsat;

endmodule

/* rtl/vec3a_front.sv */
// ----------------------------------------------------------------------------
// vec3a_front
// Decode the opcode and select the multiplier operands of each request.
// ----------------------------------------------------------------------------
module vec3a_front (
  input  logic [3:0]        func,
  input  logic [223:0]      vec_data,
  output vec3a_pkg::item_t  item
);

  vec3a_pkg::fx_t   a [0:2];
  vec3a_pkg::fx_t   b [0:2];
  vec3a_pkg::opnd_t t;
  vec3a_pkg::opnd_t omt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a[i] = vec_data[32*i +: 32];
      b[i] = vec_data[96 + 32*i +: 32];
    end
    t   = 33'(signed'(vec_data[223:192]));
    omt = vec3a_pkg::FX_ONE - t;
  end

  always_comb begin
    item    = '0;
    for (int i = 0; i < 3; i++) begin
      item.a[i] = a[i];
      item.b[i] = b[i];
    end
    unique case (func)
      vec3a_pkg::OP_ADD:  item.op.add  = 1'b1;
      vec3a_pkg::OP_DIFF: item.op.diff = 1'b1;
      vec3a_pkg::OP_NEG:  item.op.neg  = 1'b1;
      vec3a_pkg::OP_SCALE: begin
        item.op.mvec = 1'b1;
        for (int i = 0; i < 3; i++) begin
          item.m0x[i] = 33'(a[i]);
          item.m0y[i] = t;
        end
      end
      vec3a_pkg::OP_SQRLEN, vec3a_pkg::OP_LENGTH, vec3a_pkg::OP_NORM: begin
        item.op.sqrlen = (func == vec3a_pkg::OP_SQRLEN);
        item.op.len    = (func == vec3a_pkg::OP_LENGTH);
        item.op.norm   = (func == vec3a_pkg::OP_NORM);
        for (int i = 0; i < 3; i++) begin
          item.m0x[i] = 33'(a[i]);
          item.m0y[i] = 33'(a[i]);
        end
      end
      vec3a_pkg::OP_CROSS: begin
        item.op.mvec = 1'b1;
        item.m0x[0] = 33'(a[1]);  item.m0y[0] = 33'(b[2]);
        item.m1x[0] = 33'(a[2]);  item.m1y[0] = -33'(b[1]);
        item.m0x[1] = 33'(a[2]);  item.m0y[1] = 33'(b[0]);
        item.m1x[1] = 33'(a[0]);  item.m1y[1] = -33'(b[2]);
        item.m0x[2] = 33'(a[0]);  item.m0y[2] = 33'(b[1]);
        item.m1x[2] = 33'(a[1]);  item.m1y[2] = -33'(b[0]);
      end
      vec3a_pkg::OP_DOT: begin
        item.op.dot = 1'b1;
        for (int i = 0; i < 3; i++) begin
          item.m0x[i] = 33'(a[i]);
          item.m0y[i] = 33'(b[i]);
        end
      end
      vec3a_pkg::OP_LERP: begin
        item.op.mvec = 1'b1;
        for (int i = 0; i < 3; i++) begin
          item.m0x[i] = 33'(a[i]);
          item.m0y[i] = omt;
          item.m1x[i] = 33'(b[i]);
          item.m1y[i] = t;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/vec3a_queue.sv */
// ----------------------------------------------------------------------------
// vec3a_queue
// Short request queue between the decode front and the arithmetic back.
// ----------------------------------------------------------------------------
module vec3a_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  vec3a_pkg::item_t  push_item,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output vec3a_pkg::item_t  head
);

  vec3a_pkg::item_t           mem [0:vec3a_pkg::QDEPTH-1];
  logic [vec3a_pkg::QAW-1:0]  wr_r, wr_nxt;
  logic [vec3a_pkg::QAW-1:0]  rd_r, rd_nxt;
  logic [vec3a_pkg::QAW:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == (vec3a_pkg::QAW+1)'(vec3a_pkg::QDEPTH));
  assign avail = (cnt_r != '0);
  assign head  = mem[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop  ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (vec3a_pkg::QAW+1)'(push) - (vec3a_pkg::QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_item;
    end
  end

endmodule

/* rtl/vec3a_back.sv */
// ----------------------------------------------------------------------------
// vec3a_back
// Pipelined execution: products, sums and clamps, bitwise square root and
// restoring division per lane; one request per cycle, global stall.
// ----------------------------------------------------------------------------
module vec3a_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              avail,
  input  vec3a_pkg::item_t  head,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output vec3a_pkg::fx_t    res_x,
  output vec3a_pkg::fx_t    res_y,
  output vec3a_pkg::fx_t    res_z,
  output vec3a_pkg::fx_t    res_s,
  output logic              res_sat
);

  localparam int F  = vec3a_pkg::FRAC_BITS;
  localparam int DW = vec3a_pkg::DW;
  localparam int SQ = vec3a_pkg::SQ_ST;
  localparam int NV = vec3a_pkg::NV;

  logic                  en;
  logic [NV-1:0]         vld_r;
  logic                  out_v_r;

  vec3a_pkg::item_t      st0_r;
  vec3a_pkg::op_t        st1_op_r;
  vec3a_pkg::fx_t        st1_a_r [0:2];
  vec3a_pkg::fx_t        st1_b_r [0:2];
  logic signed [65:0]    p0_r [0:2];
  logic signed [65:0]    p1_r [0:2];

  vec3a_pkg::pl_t        s2;
  logic [63:0]           ss;

  logic [33:0]           sq_rem_r  [0:SQ];
  logic [31:0]           sq_root_r [0:SQ];
  logic [63:0]           sq_n_r    [0:SQ];
  vec3a_pkg::pl_t        sq_pl_r   [0:SQ];

  vec3a_pkg::pl_t        dv_in;
  logic [31:0]           dv_rem_r [0:2][1:DW];
  logic [DW-1:0]         dv_qn_r  [0:2][1:DW];
  vec3a_pkg::pl_t        dv_pl_r  [1:DW];

  vec3a_pkg::pl_t        fin;
  vec3a_pkg::pl_t        out_r;

  assign en        = !out_v_r || res_ready;
  assign pop       = en && avail;
  assign res_valid = out_v_r;
  assign res_x     = out_r.r[0];
  assign res_y     = out_r.r[1];
  assign res_z     = out_r.r[2];
  assign res_s     = out_r.s;
  assign res_sat   = out_r.sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[NV-2:0], avail};
      out_v_r <= vld_r[NV-1];
    end
  end

  // products
  always_ff @(posedge clk) begin
    if (en) begin
      st0_r    <= head;
      st1_op_r <= st0_r.op;
      for (int i = 0; i < 3; i++) begin
        st1_a_r[i] <= st0_r.a[i];
        st1_b_r[i] <= st0_r.b[i];
        p0_r[i]    <= 66'(signed'(st0_r.m0x[i])) * 66'(signed'(st0_r.m0y[i]));
        p1_r[i]    <= 66'(signed'(st0_r.m1x[i])) * 66'(signed'(st0_r.m1y[i]));
      end
    end
  end

  // sums, floors and clamps
  always_comb begin
    logic signed [66:0] pc;
    logic signed [66:0] fl;
    logic signed [67:0] dsum;
    logic signed [32:0] ev;
    vec3a_pkg::satv_t   v;
    s2      = '0;
    s2.op   = st1_op_r;
    ss      = p0_r[0][63:0] + p0_r[1][63:0] + p0_r[2][63:0];
    dsum    = 68'(p0_r[0]) + 68'(p0_r[1]) + 68'(p0_r[2]);
    s2.zero = (st1_a_r[0] == '0) && (st1_a_r[1] == '0) && (st1_a_r[2] == '0);
    for (int i = 0; i < 3; i++) begin
      s2.neg[i] = st1_a_r[i][31];
      s2.mag[i] = st1_a_r[i][31] ? 32'(-st1_a_r[i]) : 32'(st1_a_r[i]);
      pc = 67'(p0_r[i]) + 67'(p1_r[i]);
      fl = pc >>> F;
      if (st1_op_r.add) begin
        ev = 33'(st1_a_r[i]) + 33'(st1_b_r[i]);
      end else if (st1_op_r.diff) begin
        ev = 33'(st1_a_r[i]) - 33'(st1_b_r[i]);
      end else begin
        ev = -33'(st1_a_r[i]);
      end
      if (st1_op_r.mvec) begin
        v = vec3a_pkg::sat32(70'(fl));
      end else begin
        v = vec3a_pkg::sat32(70'(ev));
      end
      if (st1_op_r.add || st1_op_r.diff || st1_op_r.neg || st1_op_r.mvec) begin
        s2.r[i] = v.val;
        s2.sat  = s2.sat | v.sat;
      end
    end
    if (st1_op_r.sqrlen) begin
      v      = vec3a_pkg::sat32(70'({1'b0, ss >> F}));
      s2.s   = v.val;
      s2.sat = v.sat;
    end else if (st1_op_r.dot) begin
      v      = vec3a_pkg::sat32(70'(dsum >>> F));
      s2.s   = v.val;
      s2.sat = v.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_n_r[0]    <= ss;
      sq_pl_r[0]   <= s2;
    end
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < SQ; k++) begin : g_sq
    logic [35:0] rsh;
    logic [35:0] trial;
    logic        ge;
    assign rsh   = {sq_rem_r[k], sq_n_r[k][63:62]};
    assign trial = {2'b00, sq_root_r[k], 2'b01};
    assign ge    = (rsh >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[k+1]  <= ge ? 34'(rsh - trial) : rsh[33:0];
        sq_root_r[k+1] <= {sq_root_r[k][30:0], ge};
        sq_n_r[k+1]    <= {sq_n_r[k][61:0], 2'b00};
        sq_pl_r[k+1]   <= sq_pl_r[k];
      end
    end
  end

  always_comb begin
    dv_in      = sq_pl_r[SQ];
    dv_in.root = sq_root_r[SQ];
  end

  // restoring division, one quotient bit per stage and lane
  for (genvar j = 1; j <= DW; j++) begin : g_dv
    always_ff @(posedge clk) begin
      if (en) begin
        if (j == 1) begin
          dv_pl_r[j] <= dv_in;
        end else begin
          dv_pl_r[j] <= dv_pl_r[j-1];
        end
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_ln
      logic [31:0]   rem_i;
      logic [DW-1:0] qn_i;
      logic [31:0]   dvs;
      logic [32:0]   rsh;
      logic          ge;
      if (j == 1) begin : g_first
        assign rem_i = '0;
        assign qn_i  = {sq_pl_r[SQ].mag[l], {F{1'b0}}};
        assign dvs   = sq_root_r[SQ];
      end else begin : g_rest
        assign rem_i = dv_rem_r[l][j-1];
        assign qn_i  = dv_qn_r[l][j-1];
        assign dvs   = dv_pl_r[j-1].root;
      end
      assign rsh = {rem_i, qn_i[DW-1]};
      assign ge  = (rsh >= {1'b0, dvs});
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[l][j] <= ge ? 32'(rsh - {1'b0, dvs}) : rsh[31:0];
          dv_qn_r[l][j]  <= {qn_i[DW-2:0], ge};
        end
      end
    end
  end

  // final select for length and normalize
  always_comb begin
    logic signed [DW:0] qs;
    vec3a_pkg::satv_t   v;
    qs  = '0;
    v   = '0;
    fin = dv_pl_r[DW];
    if (fin.op.len) begin
      v       = vec3a_pkg::sat32(70'({1'b0, fin.root}));
      fin.s   = v.val;
      fin.sat = v.sat;
    end else if (fin.op.norm && !fin.zero) begin
      fin.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        qs = {1'b0, dv_qn_r[i][DW]};
        if (fin.neg[i]) begin
          qs = -qs;
        end
        v        = vec3a_pkg::sat32(70'(qs));
        fin.r[i] = v.val;
        fin.sat  = fin.sat | v.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= fin;
    end
  end

endmodule
